@@ rtl/core/minhash_lsh_band_bucketer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the MinHash LSH band bucketer
// ----------------------------------------------------------------------------
`ifndef MINHASH_LSH_BAND_BUCKETER_MACROS_SVH
`define MINHASH_LSH_BAND_BUCKETER_MACROS_SVH

// Implication in the same cycle, sampled on clk_i, held off during reset.
`define MLB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, sampled on clk_i, held off during reset.
`define MLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mlb_pkg.sv @@
// ----------------------------------------------------------------------------
// mlb_pkg
// Shared types, constants and the signature function of the band bucketer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlb_pkg;

  localparam int FeatureCount = 10;
  localparam int HashCount    = 4;
  localparam int NumBands     = 2;
  localparam int BandLen      = HashCount / NumBands;
  localparam int SigW         = 4;
  localparam int KeyW         = SigW * BandLen;
  localparam int PermW        = 4 * FeatureCount;
  localparam int DocBitsW     = FeatureCount;
  localparam int DocIdW       = 2;
  localparam int SlotOutW     = 2;
  localparam int MembersOutW  = 4;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 40;

  localparam logic [PermW-1:0] PermReset = 40'hA987654321;

  localparam int BucketSlotsDef = 4;
  localparam int DocCountDef    = 4;

  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPerm0 = 2'd0,
    CfgPerm1 = 2'd1,
    CfgPerm2 = 2'd2,
    CfgPerm3 = 2'd3
  } cfg_reg_e;

  typedef logic [SigW-1:0] sig_t;

  typedef struct packed {
    sig_t [HashCount-1:0] sig;
    logic [DocIdW-1:0]    doc_id;
  } item_t;

  typedef struct packed {
    logic [SlotOutW-1:0]    slot;
    logic [MembersOutW-1:0] members;
    logic                   full;
  } band_res_t;

  typedef struct packed {
    sig_t [HashCount-1:0]         sig;
    band_res_t [NumBands-1:0]     band;
  } result_t;

  // First permuted position whose feature is present; 0 if none.
  function automatic sig_t minhash(logic [PermW-1:0] perm, logic [DocBitsW-1:0] doc);
    sig_t        res;
    sig_t        pos;
    logic [15:0] doc_ext;
    res     = '0;
    doc_ext = 16'(doc);
    // scan downward so the lowest entry wins
    for (int i = FeatureCount - 1; i >= 0; i--) begin
      pos = perm[4*i +: 4];
      if (pos != 4'd0 && pos <= 4'(FeatureCount) && doc_ext[pos - 4'd1]) begin
        res = pos;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/mlb_front.sv @@
// ----------------------------------------------------------------------------
// mlb_front
// Holds the permutation registers, accepts documents and computes their
// signatures, then hands the signature and document number to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mlb_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mlb_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [mlb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_ready_o,
  input  wire logic [mlb_pkg::DocBitsW-1:0]   doc_bits_i,
  input  wire logic [mlb_pkg::DocIdW-1:0]     doc_id_i,
  output      logic                           push_o,
  input  wire logic                           q_full_i,
  output      mlb_pkg::item_t                 item_o
);

  logic [mlb_pkg::PermW-1:0] perm_q [mlb_pkg::HashCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < mlb_pkg::HashCount; h++) begin
        perm_q[h] <= mlb_pkg::PermReset;
      end
    end else if (cfg_we_i) begin
      unique case (mlb_pkg::cfg_reg_e'(cfg_idx_i))
        mlb_pkg::CfgPerm0: perm_q[0] <= cfg_data_i[mlb_pkg::PermW-1:0];
        mlb_pkg::CfgPerm1: perm_q[1] <= cfg_data_i[mlb_pkg::PermW-1:0];
        mlb_pkg::CfgPerm2: perm_q[2] <= cfg_data_i[mlb_pkg::PermW-1:0];
        mlb_pkg::CfgPerm3: perm_q[3] <= cfg_data_i[mlb_pkg::PermW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int h = 0; h < mlb_pkg::HashCount; h++) begin
      item_o.sig[h] = mlb_pkg::minhash(perm_q[h], doc_bits_i);
    end
    item_o.doc_id = doc_id_i;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

`default_nettype wire

@@ rtl/core/mlb_queue.sv @@
// ----------------------------------------------------------------------------
// mlb_queue
// Short FIFO between signature front end and bucket back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mlb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mlb_pkg::item_t item_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           valid_o,
  output      mlb_pkg::item_t item_o
);

  localparam int Depth = mlb_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  mlb_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mlb_back.sv @@
// ----------------------------------------------------------------------------
// mlb_back
// Bucket tables of both bands: looks up each band key, updates the matched
// or claimed slot and registers the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mlb_back #(
  parameter int BucketSlots = mlb_pkg::BucketSlotsDef,
  parameter int DocCount    = mlb_pkg::DocCountDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire mlb_pkg::item_t   item_i,
  output      logic             pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      mlb_pkg::result_t out_o
);

  localparam int SlotW = $clog2(BucketSlots);

  logic                 out_valid_q, out_valid_d;
  mlb_pkg::result_t     out_q;
  mlb_pkg::band_res_t   band_res [mlb_pkg::NumBands];
  logic [DocCount-1:0]  bit_vec;

  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_d = pop_o || (out_valid_q && !out_ready_i);
  assign bit_vec     = (32'(item_i.doc_id) < DocCount) ?
                       (DocCount'(1) << item_i.doc_id) : '0;

  for (genvar b = 0; b < mlb_pkg::NumBands; b++) begin : g_band
    logic [mlb_pkg::KeyW-1:0] key_q [BucketSlots];
    logic [DocCount-1:0]      mask_q [BucketSlots];
    logic [BucketSlots-1:0]   used_q;
    logic [mlb_pkg::KeyW-1:0] key;
    logic                     hit_found, free_found, full, claim;
    logic [SlotW-1:0]         hit_idx, free_idx, sel_idx;
    logic [DocCount-1:0]      new_mask;

    always_comb begin
      for (int j = 0; j < mlb_pkg::BandLen; j++) begin
        key[j*mlb_pkg::SigW +: mlb_pkg::SigW] = item_i.sig[b*mlb_pkg::BandLen + j];
      end
    end

    // lowest matching used slot, else lowest free slot
    always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      for (int i = BucketSlots - 1; i >= 0; i--) begin
        if (used_q[i] && key_q[i] == key) begin
          hit_found = 1'b1;
          hit_idx   = SlotW'(i);
        end
        if (!used_q[i]) begin
          free_found = 1'b1;
          free_idx   = SlotW'(i);
        end
      end
      sel_idx  = hit_found ? hit_idx : free_idx;
      claim    = !hit_found && free_found;
      full     = !hit_found && !free_found;
      new_mask = (hit_found ? mask_q[sel_idx] : '0) | bit_vec;
    end

    always_comb begin
      band_res[b].full    = full;
      band_res[b].slot    = full ? '0 : mlb_pkg::SlotOutW'(sel_idx);
      band_res[b].members = full ? '0 : mlb_pkg::MembersOutW'(new_mask);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        used_q <= '0;
        for (int i = 0; i < BucketSlots; i++) begin
          mask_q[i] <= '0;
        end
      end else if (pop_o && !full) begin
        mask_q[sel_idx] <= new_mask;
        if (claim) begin
          used_q[sel_idx] <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (pop_o && claim) begin
        key_q[sel_idx] <= key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.sig <= item_i.sig;
      for (int b = 0; b < mlb_pkg::NumBands; b++) begin
        out_q.band[b] <= band_res[b];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

@@ rtl/core/minhash_lsh_band_bucketer.sv @@
// ----------------------------------------------------------------------------
// minhash_lsh_band_bucketer
// MinHash signatures under four permutations, banded into two bucket tables.
//
//   channel   signals                             direction
//   in        in_valid_i/in_ready_o, doc fields   upstream -> block
//   out       out_valid_o/out_ready_i, results    block -> downstream
//   cfg       cfg_we_i, cfg_idx_i, cfg_data_i     write only, no wait
//
// The signature is computed on entry and queued; the bucket update and
// result register follow when the entry is popped. One document per cycle
// is sustained while the output is not stalled; each pop reads, modifies
// and writes back the bucket tables. Reset empties the tables and loads the
// identity permutations; no clearing pass is needed. A stalled output fills
// the result register and the two-entry queue (three documents) before the
// input stalls; input resumes the cycle after a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module minhash_lsh_band_bucketer #(
  parameter int BucketSlots = mlb_pkg::BucketSlotsDef,
  parameter int DocCount    = mlb_pkg::DocCountDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mlb_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [mlb_pkg::CfgDataW-1:0]      cfg_data_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [mlb_pkg::DocBitsW-1:0]      doc_bits_i,
  input  wire logic [mlb_pkg::DocIdW-1:0]        doc_id_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [mlb_pkg::SigW-1:0]          sig_0_o,
  output      logic [mlb_pkg::SigW-1:0]          sig_1_o,
  output      logic [mlb_pkg::SigW-1:0]          sig_2_o,
  output      logic [mlb_pkg::SigW-1:0]          sig_3_o,
  output      logic [mlb_pkg::SlotOutW-1:0]      band0_slot_o,
  output      logic [mlb_pkg::MembersOutW-1:0]   band0_members_o,
  output      logic                              band0_full_o,
  output      logic [mlb_pkg::SlotOutW-1:0]      band1_slot_o,
  output      logic [mlb_pkg::MembersOutW-1:0]   band1_members_o,
  output      logic                              band1_full_o
);

  logic             push, q_full, q_valid, pop;
  mlb_pkg::item_t   front_item, q_item;
  mlb_pkg::result_t res;

  mlb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .doc_bits_i (doc_bits_i),
    .doc_id_i   (doc_id_i),
    .push_o     (push),
    .q_full_i   (q_full),
    .item_o     (front_item)
  );

  mlb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  mlb_back #(
    .BucketSlots (BucketSlots),
    .DocCount    (DocCount)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign sig_0_o         = res.sig[0];
  assign sig_1_o         = res.sig[1];
  assign sig_2_o         = res.sig[2];
  assign sig_3_o         = res.sig[3];
  assign band0_slot_o    = res.band[0].slot;
  assign band0_members_o = res.band[0].members;
  assign band0_full_o    = res.band[0].full;
  assign band1_slot_o    = res.band[1].slot;
  assign band1_members_o = res.band[1].members;
  assign band1_full_o    = res.band[1].full;

endmodule

`default_nettype wire

@@ rtl/core/mlb_checker.sv @@
// ----------------------------------------------------------------------------
// mlb_checker
// Port-level checks of the band bucketer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "minhash_lsh_band_bucketer_macros.svh"

module mlb_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [mlb_pkg::SigW-1:0]        sig_0_o,
  input wire logic [mlb_pkg::SigW-1:0]        sig_1_o,
  input wire logic [mlb_pkg::SigW-1:0]        sig_2_o,
  input wire logic [mlb_pkg::SigW-1:0]        sig_3_o,
  input wire logic [mlb_pkg::SlotOutW-1:0]    band0_slot_o,
  input wire logic [mlb_pkg::MembersOutW-1:0] band0_members_o,
  input wire logic                            band0_full_o,
  input wire logic [mlb_pkg::SlotOutW-1:0]    band1_slot_o,
  input wire logic [mlb_pkg::MembersOutW-1:0] band1_members_o,
  input wire logic                            band1_full_o
);

  `MLB_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped before transfer")
  `MLB_ASSERT_SAME(a_band0_full, out_valid_o && band0_full_o, band0_slot_o == '0 && band0_members_o == '0, "band 0 full with slot data")
  `MLB_ASSERT_SAME(a_band1_full, out_valid_o && band1_full_o, band1_slot_o == '0 && band1_members_o == '0, "band 1 full with slot data")
  `MLB_ASSERT_SAME(a_sig_range, out_valid_o, sig_0_o <= 4'(mlb_pkg::FeatureCount) && sig_1_o <= 4'(mlb_pkg::FeatureCount) && sig_2_o <= 4'(mlb_pkg::FeatureCount) && sig_3_o <= 4'(mlb_pkg::FeatureCount), "signature beyond feature count")

endmodule

bind minhash_lsh_band_bucketer mlb_checker u_mlb_checker (.*);

`default_nettype wire

@@ tb/minhash_band_checker.sv @@
// ----------------------------------------------------------------------------
// minhash_band_checker
// Watches the configuration port and both channels of the band bucketer. It
// keeps its own copy of the permutations and of both bucket tables, works out
// each document's result when its input transfer happens, queues it, and
// compares every output transfer field by field with the oldest entry.
// ----------------------------------------------------------------------------
module minhash_band_checker #(
  parameter int Slots = mlb_pkg::BucketSlotsDef,
  parameter int Docs  = mlb_pkg::DocCountDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mlb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [mlb_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [mlb_pkg::DocBitsW-1:0]       doc_bits_i,
  input  logic [mlb_pkg::DocIdW-1:0]         doc_id_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [mlb_pkg::SigW-1:0]           sig_0_i,
  input  logic [mlb_pkg::SigW-1:0]           sig_1_i,
  input  logic [mlb_pkg::SigW-1:0]           sig_2_i,
  input  logic [mlb_pkg::SigW-1:0]           sig_3_i,
  input  logic [mlb_pkg::SlotOutW-1:0]       band0_slot_i,
  input  logic [mlb_pkg::MembersOutW-1:0]    band0_members_i,
  input  logic                               band0_full_i,
  input  logic [mlb_pkg::SlotOutW-1:0]       band1_slot_i,
  input  logic [mlb_pkg::MembersOutW-1:0]    band1_members_i,
  input  logic                               band1_full_i,
  output int                                 err_cnt_o,
  output int                                 pending_o
);

  logic [mlb_pkg::PermW-1:0]       perm_q [mlb_pkg::HashCount];
  logic [mlb_pkg::KeyW-1:0]        bucket_key [mlb_pkg::NumBands][Slots];
  logic                            bucket_used [mlb_pkg::NumBands][Slots];
  logic [mlb_pkg::MembersOutW-1:0] bucket_mask [mlb_pkg::NumBands][Slots];
  mlb_pkg::result_t                awaited_q [$];

  // First entry of the permutation, lowest entry first, naming a present
  // feature; entries of zero or past the feature count are skipped.
  function automatic mlb_pkg::sig_t min_position(logic [mlb_pkg::PermW-1:0] perm,
                                                 logic [mlb_pkg::DocBitsW-1:0] bits);
    mlb_pkg::sig_t pos;
    mlb_pkg::sig_t hit;
    logic          found;
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < mlb_pkg::FeatureCount; i++) begin
      pos = perm[4*i +: 4];
      if (!found && pos != '0 && int'(pos) <= mlb_pkg::FeatureCount &&
          bits[int'(pos) - 1]) begin
        hit   = pos;
        found = 1'b1;
      end
    end
    return hit;
  endfunction

  // Match among used slots, else claim the lowest free one, else report full.
  function automatic mlb_pkg::band_res_t place_band(int b, logic [mlb_pkg::KeyW-1:0] key,
                                                    logic [mlb_pkg::MembersOutW-1:0] bit_m);
    int                  hit;
    mlb_pkg::band_res_t  res;
    hit = -1;
    for (int s = 0; s < Slots; s++) begin
      if (hit < 0 && bucket_used[b][s] && bucket_key[b][s] == key) hit = s;
    end
    for (int s = 0; s < Slots; s++) begin
      if (hit < 0 && !bucket_used[b][s]) begin
        hit               = s;
        bucket_used[b][s] = 1'b1;
        bucket_key[b][s]  = key;
        bucket_mask[b][s] = '0;
      end
    end
    res = '0;
    if (hit < 0) begin
      res.full = 1'b1;
    end else begin
      bucket_mask[b][hit] |= bit_m;
      res.slot    = mlb_pkg::SlotOutW'(hit);
      res.members = bucket_mask[b][hit];
    end
    return res;
  endfunction

  function automatic mlb_pkg::result_t bucket_document(logic [mlb_pkg::DocBitsW-1:0] bits,
                                                       logic [mlb_pkg::DocIdW-1:0] id);
    mlb_pkg::result_t                res;
    logic [mlb_pkg::MembersOutW-1:0] bit_m;
    logic [mlb_pkg::KeyW-1:0]        key;
    for (int h = 0; h < mlb_pkg::HashCount; h++) res.sig[h] = min_position(perm_q[h], bits);
    bit_m = (int'(id) < Docs) ? (mlb_pkg::MembersOutW'(1) << id) : '0;
    for (int b = 0; b < mlb_pkg::NumBands; b++) begin
      for (int i = 0; i < mlb_pkg::BandLen; i++) begin
        key[mlb_pkg::SigW*i +: mlb_pkg::SigW] = res.sig[b*mlb_pkg::BandLen + i];
      end
      res.band[b] = place_band(b, key, bit_m);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      err_cnt_o++;
      if (err_cnt_o <= 10) begin
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mlb_pkg::result_t want;
    mlb_pkg::result_t got;
    if (!rst_ni) begin
      for (int h = 0; h < mlb_pkg::HashCount; h++) perm_q[h] = mlb_pkg::PermReset;
      for (int b = 0; b < mlb_pkg::NumBands; b++) begin
        for (int s = 0; s < Slots; s++) begin
          bucket_key[b][s]  = '0;
          bucket_used[b][s] = 1'b0;
          bucket_mask[b][s] = '0;
        end
      end
      awaited_q.delete();
      err_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i && int'(cfg_idx_i) < mlb_pkg::HashCount) begin
        perm_q[cfg_idx_i] = cfg_data_i[mlb_pkg::PermW-1:0];
      end
      if (in_valid_i && in_ready_i) awaited_q.push_back(bucket_document(doc_bits_i, doc_id_i));
      if (out_valid_i && out_ready_i) begin
        got.sig[0]          = sig_0_i;
        got.sig[1]          = sig_1_i;
        got.sig[2]          = sig_2_i;
        got.sig[3]          = sig_3_i;
        got.band[0].slot    = band0_slot_i;
        got.band[0].members = band0_members_i;
        got.band[0].full    = band0_full_i;
        got.band[1].slot    = band1_slot_i;
        got.band[1].members = band1_members_i;
        got.band[1].full    = band1_full_i;
        if (awaited_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) $display("result transfer with no document outstanding");
        end else begin
          want = awaited_q.pop_front();
          for (int h = 0; h < mlb_pkg::HashCount; h++) begin
            check_field($sformatf("sig_%0d", h), 8'(want.sig[h]), 8'(got.sig[h]));
          end
          for (int b = 0; b < mlb_pkg::NumBands; b++) begin
            check_field($sformatf("band%0d_slot", b), 8'(want.band[b].slot),
                        8'(got.band[b].slot));
            check_field($sformatf("band%0d_members", b), 8'(want.band[b].members),
                        8'(got.band[b].members));
            check_field($sformatf("band%0d_full", b), 8'(want.band[b].full),
                        8'(got.band[b].full));
          end
        end
      end
      pending_o = awaited_q.size();
    end
  end

endmodule

@@ tb/tb_minhash_lsh_band_bucketer.sv @@
// ----------------------------------------------------------------------------
// tb_minhash_lsh_band_bucketer
// Drives documents into the band bucketer in random bursts while the output
// side stalls on its own pattern, including one long hold that backs the
// block up. Permutations are rewritten between phases while the block is
// idle. Prediction and comparison sit in minhash_band_checker.
// ----------------------------------------------------------------------------
module tb_minhash_lsh_band_bucketer;

  localparam int CycleLimit = 150000;
  localparam int Phases     = 8;
  localparam int PhaseDocs  = 180;
  localparam int PoolSize   = 6;
  localparam int LongHoldAt = 2500;

  typedef enum int {RxSteady, RxCoin, RxMostly, RxThird} rx_mode_e;

  logic                               clk       = 1'b0;
  logic                               rst_n     = 1'b0;
  logic                               cfg_we    = 1'b0;
  mlb_pkg::cfg_reg_e                  cfg_idx   = mlb_pkg::CfgPerm0;
  logic [mlb_pkg::CfgDataW-1:0]       cfg_data  = '0;
  logic                               in_valid  = 1'b0;
  logic [mlb_pkg::DocBitsW-1:0]       doc_bits  = '0;
  logic [mlb_pkg::DocIdW-1:0]         doc_id    = '0;
  logic                               out_ready = 1'b0;
  logic                               in_ready;
  logic                               out_valid;
  logic [mlb_pkg::SigW-1:0]           sig_0, sig_1, sig_2, sig_3;
  logic [mlb_pkg::SlotOutW-1:0]       band0_slot, band1_slot;
  logic [mlb_pkg::MembersOutW-1:0]    band0_members, band1_members;
  logic                               band0_full, band1_full;
  int                                 err_cnt;
  int                                 pending;
  int                                 cycle_cnt  = 0;
  int                                 burst_left = 0;

  minhash_lsh_band_bucketer u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .doc_bits_i      (doc_bits),
    .doc_id_i        (doc_id),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .sig_0_o         (sig_0),
    .sig_1_o         (sig_1),
    .sig_2_o         (sig_2),
    .sig_3_o         (sig_3),
    .band0_slot_o    (band0_slot),
    .band0_members_o (band0_members),
    .band0_full_o    (band0_full),
    .band1_slot_o    (band1_slot),
    .band1_members_o (band1_members),
    .band1_full_o    (band1_full)
  );

  minhash_band_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .doc_bits_i      (doc_bits),
    .doc_id_i        (doc_id),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .sig_0_i         (sig_0),
    .sig_1_i         (sig_1),
    .sig_2_i         (sig_2),
    .sig_3_i         (sig_3),
    .band0_slot_i    (band0_slot),
    .band0_members_i (band0_members),
    .band0_full_i    (band0_full),
    .band1_slot_i    (band1_slot),
    .band1_members_i (band1_members),
    .band1_full_i    (band1_full),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: segments of differing stall behaviour, one long hold-off.
  initial begin : receiver
    rx_mode_e mode;
    int       seg_left;
    int       hold_left;
    int       tick;
    mode      = RxSteady;
    seg_left  = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick == LongHoldAt) hold_left = 120;
      if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          RxSteady: out_ready <= 1'b1;
          RxCoin:   out_ready <= 1'($urandom_range(0, 1));
          RxMostly: out_ready <= ($urandom_range(0, 4) != 0);
          default:  out_ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic send_doc(input logic [mlb_pkg::DocBitsW-1:0] bits,
                          input logic [mlb_pkg::DocIdW-1:0] id);
    in_valid <= 1'b1;
    doc_bits <= bits;
    doc_id   <= id;
    do @(posedge clk); while (!in_ready);
  endtask

  // Open a new burst after a random gap unless the phase runs without gaps.
  task automatic offer_doc(input logic [mlb_pkg::DocBitsW-1:0] bits,
                           input logic [mlb_pkg::DocIdW-1:0] id, input logic calm);
    int gap;
    if (burst_left == 0) begin
      gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_doc(bits, id);
  endtask

  // Drop valid and wait until every outstanding document has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_perm(input mlb_pkg::cfg_reg_e idx,
                            input logic [mlb_pkg::CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  function automatic logic [mlb_pkg::PermW-1:0] shuffled_perm();
    int                        order [mlb_pkg::FeatureCount];
    int                        j;
    int                        t;
    logic [mlb_pkg::PermW-1:0] p;
    for (int i = 0; i < mlb_pkg::FeatureCount; i++) order[i] = i + 1;
    for (int i = mlb_pkg::FeatureCount - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < mlb_pkg::FeatureCount; i++) p[4*i +: 4] = 4'(order[i]);
    return p;
  endfunction

  // Copying the partner makes neighbouring signatures agree, within a band or across the bands.
  function automatic logic [mlb_pkg::PermW-1:0] pick_perm(logic [mlb_pkg::PermW-1:0] partner);
    case ($urandom_range(0, 4))
      0:       return mlb_pkg::PermReset;
      1:       return mlb_pkg::PermW'({$urandom, $urandom});
      4:       return partner;
      default: return shuffled_perm();
    endcase
  endfunction

  initial begin : stimulus
    logic [mlb_pkg::PermW-1:0]    p0, p1, p2, p3;
    logic [mlb_pkg::DocBitsW-1:0] pool [PoolSize];
    logic [mlb_pkg::DocBitsW-1:0] bits;
    logic                         calm;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity permutations from reset: empty document, full document, reuse
    send_doc(10'h000, 2'd0);
    send_doc(10'h000, 2'd3);
    send_doc(10'h3FF, 2'd1);
    send_doc(10'h001, 2'd2);
    drain();

    // band 1 scans in reverse order, so the two tables diverge, then fill up
    write_perm(mlb_pkg::CfgPerm0, mlb_pkg::PermReset);
    write_perm(mlb_pkg::CfgPerm1, mlb_pkg::PermReset);
    write_perm(mlb_pkg::CfgPerm2, 40'h123456789A);
    write_perm(mlb_pkg::CfgPerm3, 40'h123456789A);
    cfg_we <= 1'b0;
    send_doc(10'h3FF, 2'd0);
    send_doc(10'h200, 2'd1);
    send_doc(10'h001, 2'd2);
    send_doc(10'h100, 2'd3);
    send_doc(10'h080, 2'd0);
    send_doc(10'h080, 2'd3);
    drain();

    // invalid entries (zero and past the feature count) and repeated entries
    write_perm(mlb_pkg::CfgPerm0, '0);
    write_perm(mlb_pkg::CfgPerm1, '1);
    write_perm(mlb_pkg::CfgPerm2, 40'h000000005F);
    write_perm(mlb_pkg::CfgPerm3, 40'h11111111B3);
    cfg_we <= 1'b0;
    send_doc(10'h3FF, 2'd3);
    send_doc(10'h010, 2'd1);
    send_doc(10'h000, 2'd2);
    send_doc(10'h004, 2'd0);

    for (int ph = 0; ph < Phases; ph++) begin
      drain();
      p0 = pick_perm(shuffled_perm());
      p1 = pick_perm(p0);
      p2 = pick_perm(p1);
      p3 = pick_perm(p2);
      write_perm(mlb_pkg::CfgPerm0, p0);
      write_perm(mlb_pkg::CfgPerm1, p1);
      write_perm(mlb_pkg::CfgPerm2, p2);
      write_perm(mlb_pkg::CfgPerm3, p3);
      cfg_we <= 1'b0;
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PoolSize; k++) begin
        case ($urandom_range(0, 2))
          0:       pool[k] = '0;
          1:       pool[k] = mlb_pkg::DocBitsW'(1) << $urandom_range(0, mlb_pkg::FeatureCount - 1);
          default: pool[k] = mlb_pkg::DocBitsW'($urandom);
        endcase
      end
      // mostly documents from a small set, so bucket keys recur
      for (int n = 0; n < PhaseDocs; n++) begin
        bits = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, PoolSize - 1)]
                                          : mlb_pkg::DocBitsW'($urandom);
        offer_doc(bits, mlb_pkg::DocIdW'($urandom), calm);
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
